### sv/qse_pkg.sv
package qse_pkg;

  localparam int DEPTH     = 16;
  localparam int CHANNELS  = 4;
  localparam int MODE_BITS = 4;

  localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int SUM_W     = CNT_W + 1;
  localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MEM_DEPTH = CHANNELS * DEPTH;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  localparam int CQ_DEPTH  = 2;
  localparam int CQ_PTR_W  = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int CQ_CNT_W  = $clog2(CQ_DEPTH + 1);

  typedef enum logic [0:0] {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic               kind;
    logic [1:0]         channel;
    logic signed [31:0] push_value;
  } item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] pop_value;
  } result_t;

  typedef struct packed {
    status_t             status;
    logic                write;
    logic                read;
    logic [ADDR_W-1:0]   addr;
    logic [31:0]         wdata;
  } cmd_t;

endpackage

### sv/qse_ram.sv
module qse_ram #(
  parameter int DATA_W    = 32,
  parameter int NUM_WORDS = 64
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1)-1:0] addr,
  input  logic [DATA_W-1:0]                           wdata,
  output logic [DATA_W-1:0]                           rdata
);

  logic [DATA_W-1:0] mem [NUM_WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### sv/qse_front.sv
module qse_front import qse_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  item_t                item,
  input  logic [MODE_BITS-1:0] stack_mode_mask,
  input  logic                 cmd_full,
  output logic                 cmd_push,
  output cmd_t                 cmd
);

  logic                f_valid;
  item_t               f_item;
  logic [PTR_W-1:0]    oldest [CHANNELS];
  logic [CNT_W-1:0]    fill   [CHANNELS];

  logic                ch_ok;
  logic [CH_IDX_W-1:0] idx;
  logic [PTR_W-1:0]    old;
  logic [CNT_W-1:0]    cnt;
  logic [MODE_BITS-1:0] mode_bits;
  logic                is_stack;
  logic                upd;
  logic [PTR_W-1:0]    pos;
  logic [PTR_W-1:0]    old_next;
  logic [CNT_W-1:0]    cnt_next;

  function automatic logic [PTR_W-1:0] wrap(input logic [SUM_W-1:0] x);
    if (x >= SUM_W'(DEPTH)) begin
      return PTR_W'(x - SUM_W'(DEPTH));
    end
    return PTR_W'(x);
  endfunction

  assign busy     = f_valid && cmd_full;
  assign cmd_push = f_valid && !cmd_full;

  always_comb begin
    ch_ok     = int'(f_item.channel) < CHANNELS;
    idx       = CH_IDX_W'(f_item.channel);
    old       = oldest[idx];
    cnt       = fill[idx];
    mode_bits = stack_mode_mask >> idx;
    is_stack  = mode_bits[0];
    upd       = 1'b0;
    pos       = old;
    old_next  = old;
    cnt_next  = cnt;
    cmd       = '0;
    cmd.wdata = f_item.push_value;
    if (f_item.kind == KIND_INSERT) begin
      if (!ch_ok || cnt >= CNT_W'(DEPTH)) begin
        cmd.status = ST_FULL;
      end else begin
        pos        = wrap(SUM_W'(old) + SUM_W'(cnt));
        cnt_next   = cnt + CNT_W'(1);
        upd        = 1'b1;
        cmd.write  = 1'b1;
        cmd.status = ST_INSERTED;
      end
    end else begin
      if (!ch_ok || cnt == '0) begin
        cmd.status = ST_EMPTY;
      end else begin
        if (is_stack) begin
          pos = wrap(SUM_W'(old) + SUM_W'(cnt) - SUM_W'(1));
        end else begin
          // queue removal takes the oldest word and advances past it
          old_next = (old == PTR_W'(DEPTH - 1)) ? '0 : old + PTR_W'(1);
        end
        cnt_next   = cnt - CNT_W'(1);
        upd        = 1'b1;
        cmd.read   = 1'b1;
        cmd.status = ST_REMOVED;
      end
    end
    cmd.addr = ADDR_W'(idx) * ADDR_W'(DEPTH) + ADDR_W'(pos);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        oldest[c] <= '0;
        fill[c]   <= '0;
      end
    end else begin
      if (start && !busy) begin
        f_valid <= 1'b1;
      end else if (cmd_push) begin
        f_valid <= 1'b0;
      end
      if (cmd_push && upd) begin
        oldest[idx] <= old_next;
        fill[idx]   <= cnt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      f_item <= item;
    end
  end

endmodule

### sv/qse_cmd_queue.sv
module qse_cmd_queue import qse_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t rd_cmd
);

  cmd_t                entries [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr;
  logic [CQ_PTR_W-1:0] rd_ptr;
  logic [CQ_CNT_W-1:0] count;

  assign full   = count == CQ_CNT_W'(CQ_DEPTH);
  assign empty  = count == '0;
  assign rd_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_ptr + CQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_ptr + CQ_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CQ_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CQ_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

endmodule

### sv/qse_back.sv
module qse_back import qse_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    cmd_empty,
  input  cmd_t    cmd,
  output logic    cmd_pop,
  output logic    done,
  output result_t result
);

  logic        s1_valid;
  status_t     s1_status;
  logic        s1_read;
  logic [31:0] rdata;

  // drain one command every cycle while the queue is not empty: the receiver never stalls
  assign cmd_pop = !cmd_empty;

  qse_ram #(
    .DATA_W    (32),
    .NUM_WORDS (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd_pop && cmd.write),
    .addr  (cmd.addr),
    .wdata (cmd.wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      s1_status <= cmd.status;
      s1_read   <= cmd.read;
    end
  end

  assign done             = s1_valid;
  assign result.status    = s1_status;
  assign result.pop_value = s1_read ? rdata : '0;

endmodule

### sv/four_channel_queue_stack_engine.sv
// channel   | signals                         | beat taken when
// ----------+---------------------------------+----------------------------
// request   | start, busy, item               | start high, busy low
// result    | done, result                    | every cycle done is high
// config    | cfg_valid, cfg_ready, cfg_data  | cfg_valid and cfg_ready high
//
// One request per cycle unless busy; the single store port does one access a cycle.
// A result reaches the ports through the front register, which loads at the beat,
// then the command queue, then the registered read of the word store.
// Synchronous reset empties every channel and sets the stack mask to channels 1 and 3.
// busy rises only while the command queue is full; results cannot be held off.
module four_channel_queue_stack_engine import qse_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  item_t                item,
  output logic                 done,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [MODE_BITS-1:0] cfg_data
);

  logic [MODE_BITS-1:0] stack_mode_mask;
  logic                 cmd_push;
  logic                 cmd_pop;
  logic                 cmd_full;
  logic                 cmd_empty;
  cmd_t                 wr_cmd;
  cmd_t                 rd_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_mode_mask <= MODE_BITS'(10);
    end else if (cfg_valid && cfg_ready) begin
      stack_mode_mask <= cfg_data;
    end
  end

  qse_front u_front (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .item            (item),
    .stack_mode_mask (stack_mode_mask),
    .cmd_full        (cmd_full),
    .cmd_push        (cmd_push),
    .cmd             (wr_cmd)
  );

  qse_cmd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (cmd_push),
    .wr_cmd (wr_cmd),
    .full   (cmd_full),
    .pop    (cmd_pop),
    .empty  (cmd_empty),
    .rd_cmd (rd_cmd)
  );

  qse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (rd_cmd),
    .cmd_pop   (cmd_pop),
    .done      (done),
    .result    (result)
  );

endmodule
